@@ hw/rtl/assert_macros.svh @@
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising edge, ignored while reset is held.
`define SRUC_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Check that a condition leads to another in the next cycle.
`define SRUC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  `SRUC_ASSERT(label, clk, rst_n, (ante) |=> (cons), msg)

`endif

@@ hw/rtl/sruc_pkg.sv @@
package sruc_pkg;

  // Register indexes of the configuration port
  localparam logic CFG_TEMP_F   = 1'b0;
  localparam logic CFG_PM25_AQI = 1'b1;

  // Quantity kinds on in_cmd
  localparam logic [1:0] CMD_TEMP = 2'd1;
  localparam logic [1:0] CMD_PM25 = 2'd2;

  typedef enum logic [2:0] {
    OP_PASS,
    OP_CELS,
    OP_FAHR,
    OP_AQI,
    OP_AQI_SAT
  } op_t;

  localparam int SEG_N  = 7;
  localparam int NUM_W  = 21;
  localparam int RCP_W  = 29;
  localparam int RCP_SH = 32;
  localparam int PROD_W = NUM_W + RCP_W;
  localparam int Q_W    = PROD_W - RCP_SH;

  localparam logic [16:0] KELVIN_HUND  = 17'd27315;
  localparam logic [19:0] FAHR_OFFSET  = 20'd16000;
  localparam logic [19:0] AQI_SAT_VAL  = 20'd5000;
  localparam logic [NUM_W-1:0] HALF_10 = 21'd5;
  localparam logic [NUM_W-1:0] HALF_50 = 21'd25;

  // Reciprocals ceil(2^32 / d), exact for every numerator that reaches them
  localparam logic [RCP_W-1:0] RCP_10 = 29'd429496730;
  localparam logic [RCP_W-1:0] RCP_50 = 29'd85899346;

  // AQI segments: top raw reading, low concentration (0.1 ug/m3),
  // index span in tenths, half the concentration span, reciprocal of the
  // concentration span and low index in tenths
  localparam logic [15:0] SEG_TOP [SEG_N] = '{
    16'd12, 16'd35, 16'd55, 16'd150, 16'd250, 16'd350, 16'd500};
  localparam logic [12:0] SEG_LO_C [SEG_N] = '{
    13'd0, 13'd120, 13'd354, 13'd554, 13'd1504, 13'd2504, 13'd3504};
  localparam logic [9:0] SEG_SPAN10 [SEG_N] = '{
    10'd500, 10'd500, 10'd500, 10'd500, 10'd1000, 10'd1000, 10'd1000};
  localparam logic [9:0] SEG_HALF_DEN [SEG_N] = '{
    10'd60, 10'd117, 10'd100, 10'd475, 10'd500, 10'd500, 10'd750};
  localparam logic [RCP_W-1:0] SEG_RCP [SEG_N] = '{
    29'd35791395, 29'd18354562, 29'd21474837, 29'd4521019,
    29'd4294968, 29'd4294968, 29'd2863312};
  localparam logic [12:0] SEG_BASE [SEG_N] = '{
    13'd0, 13'd500, 13'd1000, 13'd1500, 13'd2000, 13'd3000, 13'd4000};

  typedef struct packed {
    logic temp_f;
    logic pm25_aqi;
  } cfg_t;

  typedef struct packed {
    op_t         op;
    logic [2:0]  seg;
    logic [19:0] raw10;
    logic [16:0] c_hund;
    logic [10:0] d;
  } s1_t;

  typedef struct packed {
    logic             neg;
    logic [NUM_W-1:0] num;
    logic [RCP_W-1:0] rcp;
    logic [19:0]      base;
  } s2_t;

  typedef struct packed {
    logic           neg;
    logic [Q_W-1:0] q;
    logic [19:0]    base;
  } s3_t;

endpackage

@@ hw/rtl/sruc_decode.sv @@
module sruc_decode (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              vld_i,
  input  logic [1:0]        cmd_i,
  input  logic [15:0]       raw_i,
  input  sruc_pkg::cfg_t    cfg_i,
  output logic              vld_o,
  output sruc_pkg::s1_t     data_o
);

  logic          vld_r;
  sruc_pkg::s1_t data_r;
  sruc_pkg::s1_t data_nxt;
  logic [2:0]    seg;
  logic          hit;
  logic [19:0]   raw10;

  always_comb begin
    seg = 3'd0;
    hit = 1'b0;
    // lowest segment whose top covers the reading
    for (int k = sruc_pkg::SEG_N - 1; k >= 0; k--) begin
      if (raw_i <= sruc_pkg::SEG_TOP[k]) begin
        seg = 3'(k);
        hit = 1'b1;
      end
    end
  end

  always_comb begin
    raw10           = {1'b0, raw_i, 3'b000} + {3'b000, raw_i, 1'b0};
    data_nxt.seg    = seg;
    data_nxt.raw10  = raw10;
    data_nxt.c_hund = {1'b0, raw_i} - sruc_pkg::KELVIN_HUND;
    data_nxt.d      = 11'(raw10[12:0] - sruc_pkg::SEG_LO_C[seg]);
    case (cmd_i)
      sruc_pkg::CMD_TEMP: begin
        data_nxt.op = cfg_i.temp_f ? sruc_pkg::OP_FAHR : sruc_pkg::OP_CELS;
      end
      sruc_pkg::CMD_PM25: begin
        if (!cfg_i.pm25_aqi) begin
          data_nxt.op = sruc_pkg::OP_PASS;
        end else begin
          data_nxt.op = hit ? sruc_pkg::OP_AQI : sruc_pkg::OP_AQI_SAT;
        end
      end
      default: begin
        data_nxt.op = sruc_pkg::OP_PASS;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= data_nxt;
    end
  end

  assign vld_o  = vld_r;
  assign data_o = data_r;

endmodule

@@ hw/rtl/sruc_numer.sv @@
module sruc_numer (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           vld_i,
  input  sruc_pkg::s1_t  data_i,
  output logic           vld_o,
  output sruc_pkg::s2_t  data_o
);

  logic          vld_r;
  sruc_pkg::s2_t data_r;
  sruc_pkg::s2_t data_nxt;
  logic          c_neg;
  logic [16:0]   c_mag;
  logic [19:0]   c_ext;
  logic [19:0]   t_w;
  logic          t_neg;
  logic [19:0]   t_mag;
  logic [20:0]   seg_prod;

  always_comb begin
    c_neg = data_i.c_hund[16];
    c_mag = c_neg ? (17'd0 - data_i.c_hund) : data_i.c_hund;
    c_ext = {{3{data_i.c_hund[16]}}, data_i.c_hund};
    // nine times the Celsius hundredths plus the Fahrenheit offset
    t_w   = {c_ext[16:0], 3'b000} + c_ext + sruc_pkg::FAHR_OFFSET;
    t_neg = t_w[19];
    t_mag = t_neg ? (20'd0 - t_w) : t_w;
    seg_prod = {11'd0, sruc_pkg::SEG_SPAN10[data_i.seg]} * {10'd0, data_i.d};
  end

  always_comb begin
    data_nxt.neg  = 1'b0;
    data_nxt.num  = '0;
    data_nxt.rcp  = '0;
    data_nxt.base = '0;
    case (data_i.op)
      sruc_pkg::OP_CELS: begin
        data_nxt.neg = c_neg;
        data_nxt.num = {4'd0, c_mag} + sruc_pkg::HALF_10;
        data_nxt.rcp = sruc_pkg::RCP_10;
      end
      sruc_pkg::OP_FAHR: begin
        data_nxt.neg = t_neg;
        data_nxt.num = {1'b0, t_mag} + sruc_pkg::HALF_50;
        data_nxt.rcp = sruc_pkg::RCP_50;
      end
      sruc_pkg::OP_AQI: begin
        data_nxt.num  = seg_prod + {11'd0, sruc_pkg::SEG_HALF_DEN[data_i.seg]};
        data_nxt.rcp  = sruc_pkg::SEG_RCP[data_i.seg];
        data_nxt.base = {7'd0, sruc_pkg::SEG_BASE[data_i.seg]};
      end
      sruc_pkg::OP_AQI_SAT: begin
        data_nxt.base = sruc_pkg::AQI_SAT_VAL;
      end
      default: begin
        data_nxt.base = data_i.raw10;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= data_nxt;
    end
  end

  assign vld_o  = vld_r;
  assign data_o = data_r;

endmodule

@@ hw/rtl/sruc_recip_mul.sv @@
module sruc_recip_mul (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           vld_i,
  input  sruc_pkg::s2_t  data_i,
  output logic           vld_o,
  output sruc_pkg::s3_t  data_o
);

  logic                         vld_r;
  sruc_pkg::s3_t                data_r;
  sruc_pkg::s3_t                data_nxt;
  logic [sruc_pkg::PROD_W-1:0]  prod;

  always_comb begin
    prod = sruc_pkg::PROD_W'(data_i.num) * sruc_pkg::PROD_W'(data_i.rcp);
    data_nxt.neg  = data_i.neg;
    // drop the fraction bits: the quotient, already rounded by the bias
    data_nxt.q    = prod[sruc_pkg::PROD_W-1:sruc_pkg::RCP_SH];
    data_nxt.base = data_i.base;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= data_nxt;
    end
  end

  assign vld_o  = vld_r;
  assign data_o = data_r;

endmodule

@@ hw/rtl/sensor_reading_unit_converter.sv @@
// Sensor reading unit converter.
// Input channel (in_valid/in_ready): one word holds a quantity kind in_cmd
// (plain, temperature in 0.01 K, PM2.5 in ug/m3) and a 16-bit raw reading.
// Output channel (out_valid/out_ready): one word per input word, the value
// in signed tenths of the display unit, rounded to nearest, ties away from 0.
// Configuration port (cfg_we/cfg_index/cfg_wdata): register 0 picks
// Fahrenheit over Celsius, register 1 picks US AQI over plain ug/m3. Write it
// only while no word is in flight; a write lands at the next edge.
// Throughput: one word per cycle while out_ready stays high, through four
// register stages: decode and segment search, numerator build, reciprocal
// multiply, output add. A word accepted passes through them in that order.
// Each stage advances when it is empty or the one after it advances, so
// bubbles close up and in_ready stays high while any stage is free.
// Stall: with out_ready low the result holds and the stages behind it fill;
// in_ready drops only once all four hold a word. Nothing is lost or repeated.
// Reset (rst_n low at a clock edge): all stages empty, both configuration
// bits set (Fahrenheit, AQI).
`include "assert_macros.svh"

module sensor_reading_unit_converter (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic               cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_cmd,
  input  logic [15:0]        in_raw_reading,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [20:0] out_value_tenths
);

  sruc_pkg::cfg_t     cfg_r;
  sruc_pkg::s1_t      s1;
  sruc_pkg::s2_t      s2;
  sruc_pkg::s3_t      s3;
  logic               s1_vld;
  logic               s2_vld;
  logic               s3_vld;
  logic               en1;
  logic               en2;
  logic               en3;
  logic               en4;
  logic               out_valid_r;
  logic signed [20:0] value_r;
  logic signed [20:0] value_nxt;
  logic [20:0]        q_ext;

  // Configuration bits: keep bit 0 of the written word.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.temp_f   <= 1'b1;
      cfg_r.pm25_aqi <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        sruc_pkg::CFG_TEMP_F: begin
          cfg_r.temp_f <= cfg_wdata;
        end
        sruc_pkg::CFG_PM25_AQI: begin
          cfg_r.pm25_aqi <= cfg_wdata;
        end
        default: begin
          cfg_r <= cfg_r;
        end
      endcase
    end
  end

  // Advance a stage when it is empty or its successor advances.
  assign en4      = !out_valid_r || out_ready;
  assign en3      = !s3_vld || en4;
  assign en2      = !s2_vld || en3;
  assign en1      = !s1_vld || en2;
  assign in_ready = en1;

  sruc_decode u_decode (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en1),
    .vld_i  (in_valid),
    .cmd_i  (in_cmd),
    .raw_i  (in_raw_reading),
    .cfg_i  (cfg_r),
    .vld_o  (s1_vld),
    .data_o (s1)
  );

  sruc_numer u_numer (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en2),
    .vld_i  (s1_vld),
    .data_i (s1),
    .vld_o  (s2_vld),
    .data_o (s2)
  );

  sruc_recip_mul u_recip_mul (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en3),
    .vld_i  (s2_vld),
    .data_i (s2),
    .vld_o  (s3_vld),
    .data_o (s3)
  );

  // Output stage: add the signed quotient to the segment base. Plain words
  // carry a zero quotient, so the base alone passes through.
  always_comb begin
    q_ext     = {{(21 - sruc_pkg::Q_W){1'b0}}, s3.q};
    value_nxt = $signed({1'b0, s3.base} + (s3.neg ? (21'd0 - q_ext) : q_ext));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en4) begin
      out_valid_r <= s3_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      value_r <= value_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_value_tenths = value_r;

  `SRUC_ASSERT_NEXT(a_accept_fills_s1, clk, rst_n, in_valid && in_ready, s1_vld,
    "accepted word did not reach the decode stage")
  `SRUC_ASSERT(a_full_blocks_input, clk, rst_n,
    (s1_vld && s2_vld && s3_vld && out_valid_r && !out_ready) |-> !in_ready,
    "input taken while every stage is full and stalled")
  `SRUC_ASSERT(a_neg_only_temp, clk, rst_n, (s3_vld && s3.neg) |-> (s3.base == '0),
    "negative quotient with a non-zero base")
  `SRUC_ASSERT(a_out_floor, clk, rst_n, out_valid |-> (out_value_tenths >= -21'sd4597),
    "result below the coldest representable reading")

endmodule

@@ dv/testbench.sv @@
module testbench;

  // Quantity kinds the package leaves unnamed: plain and the spare code,
  // which the block must treat as plain
  localparam logic [1:0] CMD_PLAIN = 2'd0;
  localparam logic [1:0] CMD_SPARE = 2'd3;

  // Register stages between input word and output word
  localparam int PIPE_DEPTH = 4;

  // Conversion constants, in the units the block works in
  localparam longint ZERO_C_HUND   = 27315; // 0 degC in 0.01 K
  localparam longint FAHR_BIAS     = 16000; // 32 degF scaled to match 9*c/50
  localparam longint AQI_CAP       = 5000;  // saturated AQI in tenths
  localparam int     AQI_SEGS      = 7;

  // AQI breakpoints: top integer reading of each segment, concentration
  // bounds in 0.1 ug/m3 and index bounds
  localparam longint SEG_TOP_RAW [AQI_SEGS] = '{12, 35, 55, 150, 250, 350, 500};
  localparam longint SEG_C_LO [AQI_SEGS] = '{0, 120, 354, 554, 1504, 2504, 3504};
  localparam longint SEG_C_HI [AQI_SEGS] = '{120, 354, 554, 1504, 2504, 3504, 5004};
  localparam longint SEG_I_LO [AQI_SEGS] = '{0, 50, 100, 150, 200, 300, 400};
  localparam longint SEG_I_HI [AQI_SEGS] = '{50, 100, 150, 200, 300, 400, 500};

  // Holds the unit settings and the display values still owed by the block
  class tenths_board;
    bit                 temp_f   = 1'b1;
    bit                 pm25_aqi = 1'b1;
    logic signed [20:0] pending_tenths [$];
    int unsigned        checked;
    int unsigned        errors;

    task report(string what);
      errors++;
      $display("MISMATCH at %0t: %s", $time, what);
    endtask

    // Round to nearest, ties away from zero; den is positive
    function longint round_div(longint num, longint den);
      if (num >= 0) return (num + den / 2) / den;
      return -((-num + den / 2) / den);
    endfunction

    function longint aqi_tenths(longint raw);
      for (int k = 0; k < AQI_SEGS; k++) begin
        if (raw <= SEG_TOP_RAW[k])
          return SEG_I_LO[k] * 10 +
                 round_div((SEG_I_HI[k] - SEG_I_LO[k]) * 10 * (raw * 10 - SEG_C_LO[k]),
                           SEG_C_HI[k] - SEG_C_LO[k]);
      end
      return AQI_CAP;
    endfunction

    function logic signed [20:0] convert_reading(logic [1:0] cmd, logic [15:0] raw);
      longint r;
      longint v;
      r = raw;
      if (cmd == sruc_pkg::CMD_TEMP) begin
        if (temp_f) v = round_div(9 * (r - ZERO_C_HUND) + FAHR_BIAS, 50);
        else        v = round_div(r - ZERO_C_HUND, 10);
      end else if (cmd == sruc_pkg::CMD_PM25 && pm25_aqi) begin
        v = aqi_tenths(r);
      end else begin
        v = r * 10;
      end
      return v[20:0];
    endfunction

    function void set_unit(logic index, logic value);
      if (index == sruc_pkg::CFG_TEMP_F) temp_f = value;
      else                               pm25_aqi = value;
    endfunction

    function void note_reading(logic [1:0] cmd, logic [15:0] raw);
      pending_tenths.push_back(convert_reading(cmd, raw));
    endfunction

    task check_tenths(logic signed [20:0] got);
      logic signed [20:0] want;
      if (pending_tenths.size() == 0) begin
        report($sformatf("result %0d with no reading outstanding", got));
      end else begin
        want = pending_tenths.pop_front();
        checked++;
        if (got !== want)
          report($sformatf("value_tenths %0d, predicted %0d", got, want));
      end
    endtask
  endclass

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  logic               cfg_index;
  logic               cfg_wdata;
  logic               in_valid;
  logic               in_ready;
  logic [1:0]         in_cmd;
  logic [15:0]        in_raw_reading;
  logic               out_valid;
  logic               out_ready;
  logic signed [20:0] out_value_tenths;

  tenths_board sb;
  int          send_idle_pct;
  int          recv_stall_pct;
  int unsigned words_sent;

  sensor_reading_unit_converter u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_cmd           (in_cmd),
    .in_raw_reading   (in_raw_reading),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_value_tenths (out_value_tenths)
  );

  always #2 clk = ~clk;

  // Sample every handshake at the rising edge. Inputs were driven on the
  // falling edge, so nothing here races the block's own register updates.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) sb.set_unit(cfg_index, cfg_wdata);
      if (in_valid && in_ready) sb.note_reading(in_cmd, in_raw_reading);
      if (out_valid && out_ready) sb.check_tenths(out_value_tenths);
    end
  end

  // Stall the result side at random, once per cycle, at the falling edge
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Offer one word, idling first at random; return at the edge that takes it.
  // Valid stays high on return so that back-to-back words leave no gap.
  task send_word(input logic [1:0] cmd, input logic [15:0] raw);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_cmd         <= cmd;
    in_raw_reading <= raw;
    do @(posedge clk); while (!in_ready);
    words_sent++;
  endtask

  // Drop valid and hold until every outstanding word has come back, then
  // let the pipe settle
  task wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending_tenths.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 2) @(posedge clk);
  endtask

  // Write one unit setting; only called with the pipe empty
  task write_unit(input logic index, input logic value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Spread readings over the whole 16-bit range, the AQI table region and
  // the band around room temperature in 0.01 K
  function logic [15:0] pick_reading();
    case ($urandom_range(2))
      0:       return 16'($urandom_range(65535));
      1:       return 16'($urandom_range(600));
      default: return 16'($urandom_range(40000, 20000));
    endcase
  endfunction

  // Hard stop well beyond the slowest correct run
  initial begin
    #2000000;
    $display("sensor_reading_unit_converter test failed");
    $finish;
  end

  initial begin
    static logic [1:0]  edge_cmd [24] = '{
      CMD_PLAIN, CMD_PLAIN, CMD_SPARE, CMD_SPARE,
      sruc_pkg::CMD_TEMP, sruc_pkg::CMD_TEMP, sruc_pkg::CMD_TEMP, sruc_pkg::CMD_TEMP,
      sruc_pkg::CMD_PM25, sruc_pkg::CMD_PM25, sruc_pkg::CMD_PM25, sruc_pkg::CMD_PM25,
      sruc_pkg::CMD_PM25, sruc_pkg::CMD_PM25, sruc_pkg::CMD_PM25, sruc_pkg::CMD_PM25,
      sruc_pkg::CMD_PM25, sruc_pkg::CMD_PM25, sruc_pkg::CMD_PM25, sruc_pkg::CMD_PM25,
      sruc_pkg::CMD_PM25, sruc_pkg::CMD_PM25, sruc_pkg::CMD_PM25, sruc_pkg::CMD_PM25};
    static logic [15:0] edge_raw [24] = '{
      16'd0, 16'd65535, 16'd0, 16'd65535,
      16'd0, 16'd27315, 16'd65535, 16'd27310,
      16'd0, 16'd12, 16'd13, 16'd35, 16'd36, 16'd55, 16'd56, 16'd150,
      16'd151, 16'd250, 16'd251, 16'd350, 16'd351, 16'd500, 16'd501, 16'd65535};
    // Idling per phase: none, sender idle, receiver stalling, both
    static int          phase_idle  [4] = '{0, 59, 0, 26};
    static int          phase_stall [4] = '{0, 0, 59, 26};
    // Unit settings per phase: Fahrenheit/AQI, Celsius/ug, mixed both ways
    static bit          phase_fahr  [4] = '{1'b1, 1'b0, 1'b1, 1'b0};
    static bit          phase_aqi   [4] = '{1'b1, 1'b0, 1'b0, 1'b1};

    sb             = new();
    clk            = 1'b0;
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = sruc_pkg::CFG_TEMP_F;
    cfg_wdata      = 1'b0;
    in_valid       = 1'b0;
    in_cmd         = CMD_PLAIN;
    in_raw_reading = 16'd0;
    out_ready      = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    words_sent     = 0;

    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // Edges of the fields and every AQI breakpoint at the reset settings
    foreach (edge_cmd[i]) send_word(edge_cmd[i], edge_raw[i]);

    for (int ph = 0; ph < 4; ph++) begin
      wait_drained();
      write_unit(sruc_pkg::CFG_TEMP_F, phase_fahr[ph]);
      write_unit(sruc_pkg::CFG_PM25_AQI, phase_aqi[ph]);
      send_idle_pct  = phase_idle[ph];
      recv_stall_pct = phase_stall[ph];
      for (int i = 0; i < 110; i++) begin
        // Halfway through, let the block run dry before carrying on
        if (i == 55) wait_drained();
        send_word(2'($urandom_range(3)), pick_reading());
      end
    end

    wait_drained();

    $display("Sent %0d readings: field edges, every AQI segment and the cap,", words_sent);
    $display("all four unit settings under four idling patterns; %0d checked, %0d errors",
             sb.checked, sb.errors);
    if (sb.errors == 0)
      $display("sensor_reading_unit_converter test passed");
    else
      $display("sensor_reading_unit_converter test failed");
    $finish;
  end

endmodule
